FILE: hdl/scc_pkg.sv
// Shared types, constants and calendar helpers of the seconds clock with calendar.
`default_nettype none
package scc_pkg;

   // Fixed time constants
   localparam logic [31:0] GPS_EPOCH     = 32'd315964800;
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [16:0] MJD_AT_1970   = 17'd40587;
   localparam logic [11:0] FIRST_YEAR    = 12'd1970;
   localparam logic [11:0] LAST_SET_YEAR = 12'd2037;
   localparam logic [11:0] LAST_YEAR     = 12'd2106;

   // Request command codes; codes above CMD_READ behave as a read
   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_SET_UNIX = 3'd1,
      CMD_SET_GPS  = 3'd2,
      CMD_SET_DATE = 3'd3,
      CMD_READ     = 3'd4
   } cmd_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_CMD,
      S_MON,
      S_YEAR,
      S_MUL,
      S_SOD,
      S_DIV,
      S_HOUR,
      S_MIN,
      S_YDEC,
      S_MDEC,
      S_DONE
   } state_type;

   // Operands of the shared add/subtract unit
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_in_type;

   // Result of the shared unit; carry set on a subtract means a >= b
   typedef struct packed {
      logic [31:0] sum;
      logic        carry;
   } alu_out_type;

   // Finished result handed from the sequencer to the response register
   typedef struct packed {
      logic        valid;
      logic        status;
      logic [31:0] unix_seconds;
      logic [31:0] elapsed_seconds;
      logic [15:0] days;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } result_type;

   // Gregorian leap rule, valid for 1970..2106: 2000 is the only century
   // divisible by 400 in range and 2100 the only one that is not
   function automatic logic leap_year(input logic [11:0] y);
      return (y[1:0] == 2'd0) && (y != 12'd2100);
   endfunction

   function automatic logic [8:0] year_days(input logic [11:0] y);
      return leap_year(y) ? 9'd366 : 9'd365;
   endfunction

   // Days in month m (1..12) of year y
   function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] n;
      case (m)
         4'd2: begin
            n = leap_year(y) ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            n = 5'd30;
         end
         default: begin
            n = 5'd31;
         end
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/scc_req_if.sv
// Request channel of the seconds clock: valid/ready handshake and command payload.
`default_nettype none
interface scc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] seconds_value;
   logic [11:0] set_year;
   logic [3:0]  set_month;
   logic [4:0]  set_day;
   logic [4:0]  set_hour;
   logic [5:0]  set_minute;
   logic [5:0]  set_second;

   modport source (
      output valid, cmd, seconds_value, set_year, set_month, set_day,
             set_hour, set_minute, set_second,
      input  ready
   );

   modport sink (
      input  valid, cmd, seconds_value, set_year, set_month, set_day,
             set_hour, set_minute, set_second,
      output ready
   );
endinterface
`default_nettype wire

FILE: hdl/scc_rsp_if.sv
// Response channel of the seconds clock: valid/ready handshake and time payload.
`default_nettype none
interface scc_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] unix_seconds;
   logic [31:0] gps_seconds;
   logic [31:0] elapsed_seconds;
   logic [16:0] mjd;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (
      output valid, status, unix_seconds, gps_seconds, elapsed_seconds, mjd,
             year, month, day, hour, minute, second,
      input  ready
   );

   modport sink (
      input  valid, status, unix_seconds, gps_seconds, elapsed_seconds, mjd,
             year, month, day, hour, minute, second,
      output ready
   );
endinterface
`default_nettype wire

FILE: hdl/scc_alu.sv
// Shared 32-bit add/subtract-compare unit used by every sequencer step that adds, sums or divides.
`default_nettype none
module scc_alu (
   input  scc_pkg::alu_in_type  alu_in,
   output scc_pkg::alu_out_type alu_out
);

   logic [31:0] b_op;
   logic [32:0] total;

   // Invert and add one for subtract; carry out flags a >= b
   always_comb begin
      b_op  = alu_in.sub ? ~alu_in.b : alu_in.b;
      total = {1'b0, alu_in.a} + {1'b0, b_op} + {32'd0, alu_in.sub};
      alu_out.sum   = total[31:0];
      alu_out.carry = total[32];
   end

endmodule
`default_nettype wire

FILE: hdl/scc_engine.sv
// Command sequencer: time state, date entry, and calendar breakdown on the shared unit.
`default_nettype none
module scc_engine (
   input  logic                  clock,
   input  logic                  reset,
   scc_req_if.sink               req_ch,
   input  logic                  take,
   output scc_pkg::result_type   res
);

   scc_pkg::state_type   state_ff, state_in;
   scc_pkg::alu_in_type  alu_in;
   scc_pkg::alu_out_type alu_out;

   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] sv_ff, sv_in;
   logic [11:0] yy_ff, yy_in;
   logic [3:0]  mo_ff, mo_in;
   logic [4:0]  dd_ff, dd_in;
   logic [4:0]  hh_ff, hh_in;
   logic [5:0]  mi_ff, mi_in;
   logic [5:0]  ss_ff, ss_in;

   logic [31:0] time_ff, time_in;
   logic [31:0] uptime_ff, uptime_in;
   logic        status_ff, status_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] q_ff, q_in;
   logic [3:0]  step_ff, step_in;
   logic [11:0] cnt_ff, cnt_in;
   logic [15:0] days_ff, days_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   logic        date_ok;
   logic [31:0] time_new;
   logic [31:0] rem_next;
   logic [15:0] q_next;
   logic [31:0] sod_part;
   logic [31:0] prod;
   logic        last_step;

   scc_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign req_ch.ready = (state_ff == scc_pkg::S_IDLE);

   // Check a calendar date-time request
   always_comb begin
      date_ok = (yy_ff inside {[scc_pkg::FIRST_YEAR:scc_pkg::LAST_SET_YEAR]}) &&
                (mo_ff inside {[4'd1:4'd12]}) &&
                (dd_ff != 5'd0) &&
                (dd_ff <= scc_pkg::month_days(yy_ff, mo_ff)) &&
                (hh_ff <= 5'd23) && (mi_ff <= 6'd59) && (ss_ff <= 6'd59);
   end

   // Derived values around the shared unit
   always_comb begin
      sod_part  = 32'(17'(hh_ff) * 17'(scc_pkg::SECS_PER_HOUR)) +
                  32'(12'(mi_ff) * 12'(scc_pkg::SECS_PER_MIN)) + 32'(ss_ff);
      prod      = 32'(acc_ff[15:0]) * 32'(scc_pkg::SECS_PER_DAY);
      rem_next  = alu_out.carry ? alu_out.sum : acc_ff;
      q_next    = alu_out.carry ? (q_ff | (16'd1 << step_ff)) : q_ff;
      last_step = (step_ff == 4'd0);
      case (cmd_ff)
         scc_pkg::CMD_SET_UNIX: begin
            time_new = sv_ff;
         end
         scc_pkg::CMD_TICK, scc_pkg::CMD_SET_GPS: begin
            time_new = alu_out.sum;
         end
         scc_pkg::CMD_SET_DATE, scc_pkg::CMD_READ: begin
            time_new = time_ff;
         end
         default: begin
            time_new = time_ff;
         end
      endcase
   end

   // Select the operands of the shared unit
   always_comb begin
      alu_in = '{a: acc_ff, b: 32'd0, sub: 1'b0};
      case (state_ff)
         scc_pkg::S_CMD: begin
            alu_in.a = time_ff;
            if (cmd_ff == scc_pkg::CMD_TICK) begin
               alu_in.b = 32'd1;
            end else if (cmd_ff == scc_pkg::CMD_SET_GPS) begin
               alu_in.a = sv_ff;
               alu_in.b = scc_pkg::GPS_EPOCH;
            end
         end
         scc_pkg::S_MON: begin
            alu_in.b = 32'(scc_pkg::month_days(yy_ff, cnt_ff[3:0]));
         end
         scc_pkg::S_YEAR: begin
            alu_in.b = 32'(scc_pkg::year_days(cnt_ff));
         end
         scc_pkg::S_SOD: begin
            alu_in.b = sod_part;
         end
         scc_pkg::S_DIV: begin
            alu_in.b   = 32'(scc_pkg::SECS_PER_DAY) << step_ff;
            alu_in.sub = 1'b1;
         end
         scc_pkg::S_HOUR: begin
            alu_in.b   = 32'(scc_pkg::SECS_PER_HOUR) << step_ff;
            alu_in.sub = 1'b1;
         end
         scc_pkg::S_MIN: begin
            alu_in.b   = 32'(scc_pkg::SECS_PER_MIN) << step_ff;
            alu_in.sub = 1'b1;
         end
         scc_pkg::S_YDEC: begin
            alu_in.b   = 32'(scc_pkg::year_days(cnt_ff));
            alu_in.sub = 1'b1;
         end
         scc_pkg::S_MDEC: begin
            alu_in.b   = 32'(scc_pkg::month_days(year_ff, cnt_ff[3:0]));
            alu_in.sub = 1'b1;
         end
         default: begin
            alu_in.sub = 1'b0;
         end
      endcase
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scc_pkg::S_IDLE: begin
            if (req_ch.valid) state_in = scc_pkg::S_CMD;
         end
         scc_pkg::S_CMD: begin
            if (cmd_ff == scc_pkg::CMD_SET_DATE && date_ok) state_in = scc_pkg::S_MON;
            else state_in = scc_pkg::S_DIV;
         end
         scc_pkg::S_MON: begin
            if (cnt_ff >= {8'd0, mo_ff}) state_in = scc_pkg::S_YEAR;
         end
         scc_pkg::S_YEAR: begin
            if (cnt_ff >= yy_ff) state_in = scc_pkg::S_MUL;
         end
         scc_pkg::S_MUL: begin
            state_in = scc_pkg::S_SOD;
         end
         scc_pkg::S_SOD: begin
            state_in = scc_pkg::S_DIV;
         end
         scc_pkg::S_DIV: begin
            if (last_step) state_in = scc_pkg::S_HOUR;
         end
         scc_pkg::S_HOUR: begin
            if (last_step) state_in = scc_pkg::S_MIN;
         end
         scc_pkg::S_MIN: begin
            if (last_step) state_in = scc_pkg::S_YDEC;
         end
         scc_pkg::S_YDEC: begin
            if (!alu_out.carry) state_in = scc_pkg::S_MDEC;
         end
         scc_pkg::S_MDEC: begin
            if (!(cnt_ff < 12'd12 && alu_out.carry)) state_in = scc_pkg::S_DONE;
         end
         scc_pkg::S_DONE: begin
            if (take) state_in = scc_pkg::S_IDLE;
         end
         default: begin
            state_in = scc_pkg::S_IDLE;
         end
      endcase
   end

   // Update the datapath registers
   always_comb begin
      cmd_in    = cmd_ff;
      sv_in     = sv_ff;
      yy_in     = yy_ff;
      mo_in     = mo_ff;
      dd_in     = dd_ff;
      hh_in     = hh_ff;
      mi_in     = mi_ff;
      ss_in     = ss_ff;
      time_in   = time_ff;
      uptime_in = uptime_ff;
      status_in = status_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      case (state_ff)
         scc_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in = req_ch.cmd;
               sv_in  = req_ch.seconds_value;
               yy_in  = req_ch.set_year;
               mo_in  = req_ch.set_month;
               dd_in  = req_ch.set_day;
               hh_in  = req_ch.set_hour;
               mi_in  = req_ch.set_minute;
               ss_in  = req_ch.set_second;
            end
         end
         scc_pkg::S_CMD: begin
            // apply the command, then start the day division or, for a valid date, the month summing
            time_in   = time_new;
            acc_in    = time_new;
            step_in   = 4'd15;
            q_in      = 16'd0;
            status_in = (cmd_ff == scc_pkg::CMD_SET_DATE) && !date_ok;
            if (cmd_ff == scc_pkg::CMD_TICK) uptime_in = uptime_ff + 32'd1;
            if (cmd_ff == scc_pkg::CMD_SET_DATE && date_ok) begin
               acc_in = 32'(dd_ff) - 32'd1;
               cnt_in = 12'd1;
            end
         end
         scc_pkg::S_MON: begin
            if (cnt_ff < {8'd0, mo_ff}) begin
               acc_in = alu_out.sum;
               cnt_in = cnt_ff + 12'd1;
            end else begin
               cnt_in = scc_pkg::FIRST_YEAR;
            end
         end
         scc_pkg::S_YEAR: begin
            if (cnt_ff < yy_ff) begin
               acc_in = alu_out.sum;
               cnt_in = cnt_ff + 12'd1;
            end
         end
         scc_pkg::S_MUL: begin
            acc_in = prod;
         end
         scc_pkg::S_SOD: begin
            time_in = alu_out.sum;
            acc_in  = alu_out.sum;
            step_in = 4'd15;
            q_in    = 16'd0;
         end
         scc_pkg::S_DIV: begin
            acc_in  = rem_next;
            q_in    = q_next;
            step_in = step_ff - 4'd1;
            if (last_step) begin
               days_in = q_next;
               step_in = 4'd4;
               q_in    = 16'd0;
            end
         end
         scc_pkg::S_HOUR: begin
            acc_in  = rem_next;
            q_in    = q_next;
            step_in = step_ff - 4'd1;
            if (last_step) begin
               hour_in = q_next[4:0];
               step_in = 4'd5;
               q_in    = 16'd0;
            end
         end
         scc_pkg::S_MIN: begin
            acc_in  = rem_next;
            q_in    = q_next;
            step_in = step_ff - 4'd1;
            if (last_step) begin
               minute_in = q_next[5:0];
               second_in = rem_next[5:0];
               acc_in    = 32'(days_ff);
               cnt_in    = scc_pkg::FIRST_YEAR;
            end
         end
         scc_pkg::S_YDEC: begin
            if (alu_out.carry) begin
               acc_in = alu_out.sum;
               cnt_in = cnt_ff + 12'd1;
            end else begin
               year_in = cnt_ff;
               cnt_in  = 12'd1;
            end
         end
         scc_pkg::S_MDEC: begin
            if (cnt_ff < 12'd12 && alu_out.carry) begin
               acc_in = alu_out.sum;
               cnt_in = cnt_ff + 12'd1;
            end else begin
               month_in = cnt_ff[3:0];
               day_in   = acc_ff[4:0] + 5'd1;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Hold control and time state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= scc_pkg::S_IDLE;
         time_ff   <= scc_pkg::GPS_EPOCH;
         uptime_ff <= 32'd0;
      end else begin
         state_ff  <= state_in;
         time_ff   <= time_in;
         uptime_ff <= uptime_in;
      end
   end

   // Hold working payload
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      sv_ff     <= sv_in;
      yy_ff     <= yy_in;
      mo_ff     <= mo_in;
      dd_ff     <= dd_in;
      hh_ff     <= hh_in;
      mi_ff     <= mi_in;
      ss_ff     <= ss_in;
      status_ff <= status_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      step_ff   <= step_in;
      cnt_ff    <= cnt_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
   end

   // Present the finished result
   always_comb begin
      res.valid           = (state_ff == scc_pkg::S_DONE);
      res.status          = status_ff;
      res.unix_seconds    = time_ff;
      res.elapsed_seconds = uptime_ff;
      res.days            = days_ff;
      res.year            = year_ff;
      res.month           = month_ff;
      res.day             = day_ff;
      res.hour            = hour_ff;
      res.minute          = minute_ff;
      res.second          = second_ff;
   end

`ifndef SYNTHESIS
   a_sod_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scc_pkg::S_HOUR && step_ff == 4'd4) |-> (acc_ff < 32'd86400))
      else $error("seconds of day out of range after day division");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scc_pkg::S_YDEC) |->
      (cnt_ff >= scc_pkg::FIRST_YEAR && cnt_ff <= scc_pkg::LAST_YEAR))
      else $error("year counter out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scc_pkg::S_MDEC) |-> (cnt_ff >= 12'd1 && cnt_ff <= 12'd12))
      else $error("month counter out of range");

   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scc_pkg::S_DONE) |->
      (hour_ff < 5'd24 && minute_ff < 6'd60 && second_ff < 6'd60 && day_ff != 5'd0))
      else $error("broken-down time out of range");

   a_take_done: assert property (@(posedge clock) disable iff (reset)
      take |-> (state_ff == scc_pkg::S_DONE))
      else $error("result taken while sequencer not done");
`endif

endmodule
`default_nettype wire

FILE: hdl/seconds_clock_with_calendar_top.sv
// Top level of the seconds clock with calendar: sequencer plus response register.
//
// Usage: one request carries a command (tick, set Unix seconds, set GPS
// seconds, set calendar date-time, read) on req_ch; every request yields
// exactly one response on rsp_ch with status, Unix/GPS/elapsed seconds, MJD
// and the broken-down date and time.
// Sequence: after a tick, set or read request is taken, the sequencer
// divides the seconds by a day in 16 steps, then the remainder by an hour
// and a minute in 11 steps, on the single shared add/subtract unit, then
// walks the years from 1970 and the months, one year or month per cycle.
// A valid set date-time first sums the days of its months and years,
// multiplies them by a day and adds the seconds of the day.
// req_ch.ready is high only while the sequencer is idle; one request is in
// work at a time. The finished result moves into a response register, so the
// sequencer is free for the next request while the response waits on ready.
// A stalled receiver holds the response; the sequencer waits if it finishes
// a second result before the first is taken.
// Reset (synchronous, active high) sets the time to the GPS epoch
// (315964800 s), clears the elapsed count and empties the response register.
`default_nettype none
module seconds_clock_with_calendar_top (
   input  logic      clock,
   input  logic      reset,
   scc_req_if.sink   req_ch,
   scc_rsp_if.source rsp_ch
);

   scc_pkg::result_type res;
   scc_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         gps_ff, gps_in;
   logic [16:0]         mjd_ff, mjd_in;
   logic                take;

   scc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (take),
      .res    (res)
   );

   // Move a finished result into the response register when it is free
   always_comb begin
      take         = res.valid && (!out_valid_ff || rsp_ch.ready);
      out_valid_in = take ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_in       = take ? res : out_ff;
      gps_in       = gps_ff;
      mjd_in       = mjd_ff;
      if (take) begin
         gps_in = (res.unix_seconds >= scc_pkg::GPS_EPOCH) ?
                  (res.unix_seconds - scc_pkg::GPS_EPOCH) : 32'd0;
         mjd_in = 17'(res.days) + scc_pkg::MJD_AT_1970;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      gps_ff <= gps_in;
      mjd_ff <= mjd_in;
   end

   // Drive the response channel
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_ff.status;
   assign rsp_ch.unix_seconds    = out_ff.unix_seconds;
   assign rsp_ch.gps_seconds     = gps_ff;
   assign rsp_ch.elapsed_seconds = out_ff.elapsed_seconds;
   assign rsp_ch.mjd             = mjd_ff;
   assign rsp_ch.year            = out_ff.year;
   assign rsp_ch.month           = out_ff.month;
   assign rsp_ch.day             = out_ff.day;
   assign rsp_ch.hour            = out_ff.hour;
   assign rsp_ch.minute          = out_ff.minute;
   assign rsp_ch.second          = out_ff.second;

endmodule
`default_nettype wire
